@@ src/tfp_pkg.sv @@
// tfp_pkg: shared types, register indexes and constants for the focal-plane projection unit
// depends on nothing; used by every module of the block but tfp_delay
package tfp_pkg;

	// register indexes of the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_Z1_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z2_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z1_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Z2_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COT_X = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COT_Y = 3'd6;

	// pipeline depths, quotient width and angle clamp
	localparam int FRONT_LAT = 3;
	localparam int DIV_LAT = 20;
	localparam int QBITS = 17;
	localparam int ANG_MAX = 25133;

	// event item
	typedef struct packed {
		logic               first_present;
		logic               second_present;
		logic signed [15:0] x_first;
		logic signed [15:0] y_first;
		logic signed [15:0] x_second;
		logic signed [15:0] y_second;
	} evt_t;

	// result item
	typedef struct packed {
		logic               track_valid;
		logic signed [15:0] x_focal;
		logic signed [15:0] theta_focal;
		logic signed [15:0] y_focal;
		logic signed [15:0] phi_focal;
	} res_t;

	// per-plane result out of a lane
	typedef struct packed {
		logic               ok;
		logic signed [15:0] pos;
		logic signed [15:0] ang;
	} lane_res_t;

	// depth of one lane from input to result
	function automatic int lane_lat(input int steps);
		int a;
		a = steps + 4;
		return (a > FRONT_LAT + DIV_LAT) ? a : FRONT_LAT + DIV_LAT;
	endfunction

	// atan(2^-i) in units of 2^-30 rad
	function automatic logic [33:0] atan_entry(input int idx);
		logic [33:0] r;
		case (idx)
			0: r = 34'd843314857;
			1: r = 34'd497837829;
			2: r = 34'd263043837;
			3: r = 34'd133525159;
			4: r = 34'd67021687;
			5: r = 34'd33543516;
			6: r = 34'd16775851;
			7: r = 34'd8388437;
			8: r = 34'd4194283;
			9: r = 34'd2097149;
			10: r = 34'd1048576;
			11: r = 34'd524288;
			12: r = 34'd262144;
			13: r = 34'd131072;
			14: r = 34'd65536;
			15: r = 34'd32768;
			16: r = 34'd16384;
			17: r = 34'd8192;
			18: r = 34'd4096;
			19: r = 34'd2048;
			20: r = 34'd1024;
			21: r = 34'd512;
			22: r = 34'd256;
			23: r = 34'd128;
			24: r = 34'd64;
			25: r = 34'd32;
			26: r = 34'd16;
			27: r = 34'd8;
			28: r = 34'd4;
			29: r = 34'd2;
			30: r = 34'd1;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

endpackage

@@ src/tfp_delay.sv @@
// tfp_delay: enable-gated register delay line of configurable depth
// no package dependency
module tfp_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [W-1:0] dly_s [0:DEPTH-1];
			// shift line
			always_ff @(posedge clk) begin
				if (en) begin
					dly_s[0] <= d;
					for (int i = 1; i < DEPTH; i++) dly_s[i] <= dly_s[i-1];
				end
			end
			assign q = dly_s[DEPTH-1];
		end
	endgenerate

endmodule

@@ src/tfp_div.sv @@
// tfp_div: pipelined signed divide, rounded half away from zero, saturated to 16 bits
// uses tfp_pkg; one quotient bit per stage
module tfp_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] num,
	input  logic signed [49:0] den,
	output logic signed [15:0] quo
);

	localparam int QB = tfp_pkg::QBITS;

	logic        neg_q;
	logic [63:0] un_q;
	logic [49:0] ud_q;

	logic [66:0]   rem_s [0:QB];
	logic [QB-1:0] q_s   [0:QB];
	logic [49:0]   ud_s  [0:QB];
	logic          neg_s [0:QB];
	logic          sat_s [0:QB];

	logic [QB:0] qr;

	// magnitudes and sign of the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			neg_q <= num[63] ^ den[49];
			un_q <= num[63] ? 64'(-num) : 64'(num);
			ud_q <= den[49] ? 50'(-den) : 50'(den);
		end
	end

	// overflow check against 2^17 half-units, remainder start
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {2'b00, un_q, 1'b0};
			sat_s[0] <= ({3'b000, un_q} << 1) >= ({17'd0, ud_q} << QB);
			ud_s[0] <= ud_q;
			neg_s[0] <= neg_q;
			q_s[0] <= '0;
		end
	end

	// restoring division, one bit a stage, msb first
	generate
		for (genvar j = 0; j < QB; j++) begin : g_bit
			logic [67:0] t_c;
			assign t_c = {1'b0, rem_s[j]} - ({18'd0, ud_s[j]} << (QB - 1 - j));
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= t_c[67] ? rem_s[j] : t_c[66:0];
					q_s[j+1] <= q_s[j] | ({{(QB-1){1'b0}}, !t_c[67]} << (QB - 1 - j));
					ud_s[j+1] <= ud_s[j];
					neg_s[j+1] <= neg_s[j];
					sat_s[j+1] <= sat_s[j];
				end
			end
		end
	endgenerate

	// round the half-unit quotient, saturate
	assign qr = ({1'b0, q_s[QB]} + 18'd1) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[QB]) begin
				quo <= neg_s[QB] ? -16'sd32768 : 16'sd32767;
			end else if (neg_s[QB]) begin
				quo <= (qr > 18'd32768) ? -16'sd32768 : 16'(-qr);
			end else begin
				quo <= (qr > 18'd32767) ? 16'sd32767 : 16'(qr);
			end
		end
	end

endmodule

@@ src/tfp_cordic.sv @@
// tfp_cordic: pipelined vectoring CORDIC, angle of (dz, dx) in 1/16 mrad
// uses tfp_pkg for the arctangent table
module tfp_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [16:0] dx,
	input  logic signed [16:0] dz,
	output logic signed [15:0] ang
);

	logic signed [39:0] x_s [0:STEPS];
	logic signed [39:0] y_s [0:STEPS];
	logic signed [33:0] z_s [0:STEPS];
	logic signed [48:0] v_q;
	logic [48:0]        m_c;
	logic [18:0]        mr_c;

	// fold into the right half plane, scale by 2^20
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= (dz[16] ? 40'(-dz) : 40'(dz)) <<< 20;
			y_s[0] <= (dz[16] ? 40'(-dx) : 40'(dx)) <<< 20;
			z_s[0] <= '0;
		end
	end

	// micro-rotations
	generate
		for (genvar i = 0; i < STEPS; i++) begin : g_step
			always_ff @(posedge clk) begin
				if (en) begin
					if (!y_s[i][39]) begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + $signed(tfp_pkg::atan_entry(i));
					end else begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - $signed(tfp_pkg::atan_entry(i));
					end
				end
			end
		end
	endgenerate

	// scale to 1/16 mrad
	always_ff @(posedge clk) begin
		if (en) v_q <= 49'(z_s[STEPS]) * 49'sd16000;
	end

	// round half away from zero, clamp
	assign m_c = v_q[48] ? 49'(-v_q) : 49'(v_q);
	assign mr_c = 19'((m_c + 49'(1 << 29)) >> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			if (mr_c > 19'(tfp_pkg::ANG_MAX)) begin
				ang <= v_q[48] ? -16'(tfp_pkg::ANG_MAX) : 16'(tfp_pkg::ANG_MAX);
			end else begin
				ang <= v_q[48] ? 16'(-mr_c) : 16'(mr_c);
			end
		end
	end

endmodule

@@ src/tfp_lane.sv @@
// tfp_lane: one plane: line fit, focal intersection divide and angle
// uses tfp_pkg, tfp_delay, tfp_div, tfp_cordic
module tfp_lane #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] a1,
	input  logic signed [15:0] a2,
	input  logic signed [15:0] z1,
	input  logic signed [15:0] z2,
	input  logic signed [15:0] focal,
	input  logic signed [31:0] cot,
	output tfp_pkg::lane_res_t res
);

	localparam int LAT = tfp_pkg::lane_lat(CORDIC_STEPS);
	localparam int DIV_PAD = LAT - tfp_pkg::FRONT_LAT - tfp_pkg::DIV_LAT;
	localparam int ANG_PAD = LAT - CORDIC_STEPS - 4;

	logic signed [16:0] dx_c, dz_c;
	logic signed [16:0] dx_s1, dz_s1;
	logic signed [31:0] a1z2_s1, a2z1_s1;
	logic signed [32:0] dxf_s1;
	logic signed [48:0] cotdz_s1;
	logic signed [33:0] p_s2;
	logic signed [49:0] d_s2, d_s3;
	logic               dzz_s2, ok_s3;
	logic signed [63:0] num_s3;
	logic signed [15:0] quo, ang;
	logic signed [15:0] pos_d, ang_d;
	logic               ok_d;

	assign dx_c = 17'(a2) - 17'(a1);
	assign dz_c = 17'(z2) - 17'(z1);

	// differences and first products
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx_c;
			dz_s1 <= dz_c;
			a1z2_s1 <= 32'(a1) * 32'(z2);
			a2z1_s1 <= 32'(a2) * 32'(z1);
			dxf_s1 <= 33'(dx_c) * 33'(focal);
			cotdz_s1 <= 49'(cot) * 49'(dz_c);
		end
	end

	// numerator before tilt, denominator
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= 34'(dxf_s1) + 34'(a1z2_s1) - 34'(a2z1_s1);
			d_s2 <= 50'(cotdz_s1) - (50'(dx_s1) <<< 16);
			dzz_s2 <= (dz_s1 == 17'sd0);
		end
	end

	// tilted numerator
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= 64'(cot) * 64'(p_s2);
			d_s3 <= d_s2;
			ok_s3 <= !dzz_s2 && (d_s2 != 50'sd0);
		end
	end

	tfp_div u_div (
		.clk(clk), .en(en), .num(num_s3), .den(d_s3), .quo(quo)
	);

	tfp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .en(en), .dx(dx_s1), .dz(dz_s1), .ang(ang)
	);

	// line up the three branches
	tfp_delay #(.W(1), .DEPTH(LAT - tfp_pkg::FRONT_LAT)) u_ok_dly (
		.clk(clk), .en(en), .d(ok_s3), .q(ok_d)
	);
	tfp_delay #(.W(16), .DEPTH(DIV_PAD)) u_pos_dly (
		.clk(clk), .en(en), .d(quo), .q(pos_d)
	);
	tfp_delay #(.W(16), .DEPTH(ANG_PAD)) u_ang_dly (
		.clk(clk), .en(en), .d(ang), .q(ang_d)
	);

	assign res.ok = ok_d;
	assign res.pos = pos_d;
	assign res.ang = ang_d;

endmodule

@@ src/two_point_focal_plane_projection_unit.sv @@
// two_point_focal_plane_projection_unit: top level, config registers and pipeline control
// uses tfp_pkg, tfp_lane, tfp_delay
//
// Usage: the evt channel takes one event item (presence flags and X/Y hits of
// two detectors) per cycle, accepted when evt_valid is high and evt_stall low.
// The res channel gives one result item per event in order: track validity,
// X and Y focal coordinates and the two track angles. Invalid tracks carry
// zero fields. The cfg channel writes the seven registers by index; cfg_ready
// is always high; writes must be made while no event is in flight, which the
// block itself does not enforce. The 17-stage restoring divider or the CORDIC
// chain, whichever is longer, sets the pipeline depth. Throughput is one item
// per cycle while res_stall does not hold a waiting result.
// When res_stall holds a waiting result, the whole pipeline freezes and
// evt_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults.
module two_point_focal_plane_projection_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             evt_valid,
	output logic                             evt_stall,
	input  tfp_pkg::evt_t                    evt,
	output logic                             res_valid,
	input  logic                             res_stall,
	output tfp_pkg::res_t                    res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int LAT = tfp_pkg::lane_lat(CORDIC_STEPS);

	logic signed [15:0] z1x_q, z2x_q, z1y_q, z2y_q, focal_q;
	logic signed [31:0] cotx_q, coty_q;
	logic               en;
	logic [LAT-1:0]     vld_s;
	logic [1:0]         pres_d;
	tfp_pkg::lane_res_t rx, ry;
	logic               ok_c;

	assign cfg_ready = 1'b1;
	assign en = !(res_valid && res_stall);
	assign evt_stall = !en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1x_q <= 16'sd0;
			z2x_q <= 16'sd16;
			z1y_q <= 16'sd0;
			z2y_q <= 16'sd16;
			focal_q <= 16'sd0;
			cotx_q <= 32'sh7fffffff;
			coty_q <= 32'sh7fffffff;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tfp_pkg::REG_Z1_X: z1x_q <= cfg_data[15:0];
				tfp_pkg::REG_Z2_X: z2x_q <= cfg_data[15:0];
				tfp_pkg::REG_Z1_Y: z1y_q <= cfg_data[15:0];
				tfp_pkg::REG_Z2_Y: z2y_q <= cfg_data[15:0];
				tfp_pkg::REG_FOCAL: focal_q <= cfg_data[15:0];
				tfp_pkg::REG_COT_X: cotx_q <= cfg_data;
				tfp_pkg::REG_COT_Y: coty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			res_valid <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], evt_valid};
			res_valid <= vld_s[LAT-1];
		end
	end

	tfp_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
		.clk(clk), .en(en), .a1(evt.x_first), .a2(evt.x_second),
		.z1(z1x_q), .z2(z2x_q), .focal(focal_q), .cot(cotx_q), .res(rx)
	);

	tfp_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
		.clk(clk), .en(en), .a1(evt.y_first), .a2(evt.y_second),
		.z1(z1y_q), .z2(z2y_q), .focal(focal_q), .cot(coty_q), .res(ry)
	);

	tfp_delay #(.W(2), .DEPTH(LAT)) u_pres_dly (
		.clk(clk), .en(en), .d({evt.first_present, evt.second_present}), .q(pres_d)
	);

	// result register, zero fields for invalid tracks
	assign ok_c = pres_d[1] && pres_d[0] && rx.ok && ry.ok;

	always_ff @(posedge clk) begin
		if (en) begin
			res.track_valid <= ok_c;
			res.x_focal <= ok_c ? rx.pos : 16'sd0;
			res.theta_focal <= ok_c ? rx.ang : 16'sd0;
			res.y_focal <= ok_c ? ry.pos : 16'sd0;
			res.phi_focal <= ok_c ? ry.ang : 16'sd0;
		end
	end

endmodule

@@ src/tfp_chk.sv @@
// tfp_chk: port-level checks for the projection unit, bound to the top level
// uses tfp_pkg types
module tfp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          evt_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input tfp_pkg::res_t                 res
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a blocked output blocks the input
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> evt_stall)
		else $error("input taken while output blocked");

	// invalid tracks carry zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.track_valid |-> res.x_focal == 16'sd0 &&
		res.theta_focal == 16'sd0 && res.y_focal == 16'sd0 && res.phi_focal == 16'sd0)
		else $error("invalid track with nonzero fields");

	// angles stay in the clamp range
	a_ang: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.theta_focal <= 16'sd25133 && res.theta_focal >= -16'sd25133 &&
		res.phi_focal <= 16'sd25133 && res.phi_focal >= -16'sd25133)
		else $error("angle out of range");

endmodule

bind two_point_focal_plane_projection_unit tfp_chk u_chk (.*);
